/* rtl/lr_table_parse_engine_defines.svh */
// Assertion macros for the LR table parse engine.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef LR_TABLE_PARSE_ENGINE_DEFINES_SVH
`define LR_TABLE_PARSE_ENGINE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define LRP_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("lrp: same-cycle check failed");

// next-cycle implication, disabled in reset
`define LRP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("lrp: next-cycle check failed");

`endif

/* rtl/lrp_pkg.sv */
// Package for the LR table parse engine: field widths, codes, entry and record types.
// No dependencies.
package lrp_pkg;

    localparam int STATE_W = 8;
    localparam int SYM_W   = 6;
    localparam int TGT_W   = 8;
    localparam int RULE_W  = 7;
    localparam int LEN_W   = 4;
    localparam int OP_W    = 3;
    localparam int EV_W    = 3;

    localparam int STATE_COUNT_DEF  = 256;
    localparam int SYMBOL_COUNT_DEF = 64;
    localparam int RULE_COUNT_DEF   = 128;
    localparam int STACK_DEPTH_DEF  = 64;
    localparam int MAX_RHS_DEF      = 15;

    localparam int RESULT_LIMIT = 64;
    localparam int N_W          = $clog2(RESULT_LIMIT);

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 32;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD_ACTION = 3'd0,
        OP_LOAD_GOTO   = 3'd1,
        OP_LOAD_RULE   = 3'd2,
        OP_TOKEN       = 3'd3,
        OP_START       = 3'd4
    } lrp_op_t;

    typedef enum logic [1:0] {
        ACT_REJECT = 2'd0,
        ACT_SHIFT  = 2'd1,
        ACT_REDUCE = 2'd2,
        ACT_ACCEPT = 2'd3
    } lrp_kind_t;

    typedef enum logic [EV_W-1:0] {
        EV_SHIFT    = 3'd0,
        EV_REDUCE   = 3'd1,
        EV_ACCEPT   = 3'd2,
        EV_ACTERR   = 3'd3,
        EV_GOTOERR  = 3'd4,
        EV_STACKERR = 3'd5,
        EV_IGNORED  = 3'd6,
        EV_DONE     = 3'd7
    } lrp_ev_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_ACT,
        ST_RULE,
        ST_POP,
        ST_GOTO
    } lrp_fsm_t;

    typedef struct packed {
        lrp_kind_t          kind;
        logic [TGT_W-1:0]   target;
    } lrp_action_t;

    typedef struct packed {
        logic               valid;
        logic [TGT_W-1:0]   target;
    } lrp_goto_t;

    typedef struct packed {
        logic [SYM_W-1:0]   left;
        logic [LEN_W-1:0]   len;
        logic [SYM_W-1:0]   first;
    } lrp_rule_t;

    // input tdata layout, lowest field last
    typedef struct packed {
        logic [SYM_W-1:0]   rule_first_right;
        logic [LEN_W-1:0]   rule_length;
        logic [SYM_W-1:0]   rule_left;
        logic [RULE_W-1:0]  rule_number;
        logic               goto_valid;
        logic [TGT_W-1:0]   entry_target;
        logic [1:0]         action_kind;
        logic [SYM_W-1:0]   table_symbol;
        logic [STATE_W-1:0] table_state;
    } lrp_item_t;

    typedef struct packed {
        lrp_ev_t            ev;
        logic               last;
        logic [SYM_W-1:0]   error_symbol;
        logic [STATE_W-1:0] error_state;
        logic [RULE_W-1:0]  reduced_rule;
        logic [STATE_W-1:0] new_state;
    } lrp_rec_t;

endpackage

/* rtl/lr_table_parse_engine.sv */
// LR table parse engine top level: sequencer around table, rule and stack memories.
// Depends on lrp_pkg and lr_table_parse_engine_defines.svh.
//
// After reset the block sweeps the ACTION and GOTO memories to reject/invalid, one
// entry per cycle, over all T_ROWS x 2^ceil(log2(T_COLS)) entries (16384 at the
// defaults, row and column counts capped at 256 and 64); s_tready stays low during the
// sweep, the epsilon register can be written at any time. Load, start, ignored and
// unknown items are taken in ST_IDLE and answered from ST_EXEC. A token is taken in
// ST_IDLE and passes ST_ACT, ST_RULE, ST_POP and ST_GOTO for each completed reduction
// (action read, rule read, stack read, goto read, each a registered memory read),
// then the ending step: ST_ACT ends a shift, accept, action error or reduce chain
// limit, ST_RULE a reduction that underflows the stack, ST_GOTO a reduction that
// fails its goto lookup or overflows the stack. Records go out through one output
// register; a stalled m_tready holds the sequencer at the next record.
`include "lr_table_parse_engine_defines.svh"

module lr_table_parse_engine #(
    parameter int STATE_COUNT  = lrp_pkg::STATE_COUNT_DEF,
    parameter int SYMBOL_COUNT = lrp_pkg::SYMBOL_COUNT_DEF,
    parameter int RULE_COUNT   = lrp_pkg::RULE_COUNT_DEF,
    parameter int STACK_DEPTH  = lrp_pkg::STACK_DEPTH_DEF,
    parameter int MAX_RHS      = lrp_pkg::MAX_RHS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lrp_pkg::SYM_W-1:0]           cfg_data,   // epsilon_symbol
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // table_state, table_symbol, action_kind, entry_target, goto_valid,
    // rule_number, rule_left, rule_length, rule_first_right
    input  logic [lrp_pkg::IN_DATA_W-1:0]       s_tdata,
    input  logic [lrp_pkg::OP_W-1:0]            s_tuser,    // op
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // new_state, reduced_rule, error_state, error_symbol, zero fill
    output logic [lrp_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic [lrp_pkg::EV_W-1:0]            m_tuser,    // event_res
    output logic                                m_tlast     // last
);
    import lrp_pkg::*;

    localparam int T_ROWS     = (STATE_COUNT < 256) ? STATE_COUNT : 256;
    localparam int T_COLS     = (SYMBOL_COUNT < 64) ? SYMBOL_COUNT : 64;
    localparam int ROW_W      = (T_ROWS > 1) ? $clog2(T_ROWS) : 1;
    localparam int COL_W      = (T_COLS > 1) ? $clog2(T_COLS) : 1;
    localparam int TBL_AW     = ROW_W + COL_W;
    localparam int TBL_DEPTH  = T_ROWS << COL_W;
    localparam int RULE_DEPTH = (RULE_COUNT < 128) ? RULE_COUNT : 128;
    localparam int RULE_AW    = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1;
    localparam int SP_W       = $clog2(STACK_DEPTH + 1);
    localparam int SA_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    lrp_action_t          action_mem [TBL_DEPTH];
    lrp_goto_t            goto_mem   [TBL_DEPTH];
    lrp_rule_t            rule_mem   [RULE_DEPTH];
    logic [STATE_W-1:0]   stack_mem  [STACK_DEPTH];

    lrp_fsm_t             state_reg, state_next;
    logic [TBL_AW-1:0]    clr_reg, clr_next;
    logic [SP_W-1:0]      sp_reg, sp_next;
    logic [STATE_W-1:0]   top_reg, top_next;
    logic                 done_reg, done_next;
    logic [N_W-1:0]       n_reg, n_next;
    logic [SYM_W-1:0]     eps_reg;
    lrp_item_t            item_reg, item_next;
    lrp_op_t              op_reg, op_next;
    logic [SYM_W-1:0]     left_reg, left_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic [RULE_W-1:0]    rnum_reg, rnum_next;
    logic                 m_valid_reg;
    lrp_rec_t             m_rec_reg;

    logic [TBL_AW-1:0]    tbl_addr;
    logic [STATE_W-1:0]   tbl_row;
    logic [SYM_W-1:0]     tbl_col;
    logic                 tbl_re, tbl_ok, lk_ok_reg;
    logic                 tbl_we_act, tbl_we_goto;
    lrp_action_t          tbl_wact, act_rd_reg, act_ent;
    lrp_goto_t            tbl_wgoto, goto_rd_reg, goto_ent;
    logic                 rule_we, rule_re;
    logic [RULE_AW-1:0]   rule_waddr, rule_raddr;
    lrp_rule_t            rule_wdata, rule_rd_reg;
    logic                 stk_we, stk_re;
    logic [SA_W-1:0]      stk_waddr, stk_raddr;
    logic [STATE_W-1:0]   stk_wdata, stk_rd_reg;

    lrp_item_t            s_item;
    logic                 out_free, emit;
    lrp_rec_t             rec;
    logic [LEN_W-1:0]     eff_len, rl_len;
    logic [SP_W-1:0]      sp_pop, sp_pop_m1;
    logic [STATE_W-1:0]   gs;
    logic                 parse_end;

    function automatic logic in_tbl(logic [STATE_W-1:0] st, logic [SYM_W-1:0] sym);
        return (int'(st) < STATE_COUNT) && (int'(sym) < SYMBOL_COUNT);
    endfunction

    assign s_item    = lrp_item_t'(s_tdata);
    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign out_free  = !m_valid_reg || m_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tuser   = m_rec_reg.ev;
    assign m_tlast   = m_rec_reg.last;
    assign m_tdata   = {3'b000, m_rec_reg.error_symbol, m_rec_reg.error_state,
                        m_rec_reg.reduced_rule, m_rec_reg.new_state};

    assign act_ent   = lk_ok_reg ? act_rd_reg : '0;
    assign goto_ent  = lk_ok_reg ? goto_rd_reg : '0;
    assign tbl_addr  = (state_reg == ST_CLEAR) ? clr_reg
                                               : {tbl_row[ROW_W-1:0], tbl_col[COL_W-1:0]};

    assign eff_len   = (rule_rd_reg.len == LEN_W'(1) && rule_rd_reg.first == eps_reg)
                       ? '0 : rule_rd_reg.len;
    assign sp_pop    = sp_reg - SP_W'(eff_len);
    assign sp_pop_m1 = sp_pop - SP_W'(1);
    assign gs        = (len_reg == '0) ? top_reg : stk_rd_reg;
    assign rl_len    = (int'(item_reg.rule_length) > MAX_RHS) ? LEN_W'(MAX_RHS)
                                                              : item_reg.rule_length;
    assign parse_end = emit && (rec.ev inside {EV_ACCEPT, EV_ACTERR, EV_GOTOERR, EV_STACKERR});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            sp_reg    <= '0;
            top_reg   <= '0;
            done_reg  <= 1'b1;
            n_reg     <= '0;
            eps_reg   <= '0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            sp_reg    <= sp_next;
            top_reg   <= top_next;
            done_reg  <= done_next;
            n_reg     <= n_next;
            if (cfg_valid) begin
                eps_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        op_reg   <= op_next;
        left_reg <= left_next;
        len_reg  <= len_next;
        rnum_reg <= rnum_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_rec_reg <= rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (tbl_we_act) begin
            action_mem[tbl_addr] <= tbl_wact;
        end
        if (tbl_we_goto) begin
            goto_mem[tbl_addr] <= tbl_wgoto;
        end
        if (tbl_re) begin
            act_rd_reg  <= action_mem[tbl_addr];
            goto_rd_reg <= goto_mem[tbl_addr];
            lk_ok_reg   <= tbl_ok;
        end
    end

    always_ff @(posedge aclk) begin
        if (rule_we) begin
            rule_mem[rule_waddr] <= rule_wdata;
        end
        if (rule_re) begin
            rule_rd_reg <= rule_mem[rule_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (stk_we) begin
            stack_mem[stk_waddr] <= stk_wdata;
        end
        if (stk_re) begin
            stk_rd_reg <= stack_mem[stk_raddr];
        end
    end

    always_comb begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        sp_next     = sp_reg;
        top_next    = top_reg;
        done_next   = done_reg;
        n_next      = n_reg;
        item_next   = item_reg;
        op_next     = op_reg;
        left_next   = left_reg;
        len_next    = len_reg;
        rnum_next   = rnum_reg;
        tbl_row     = '0;
        tbl_col     = '0;
        tbl_re      = 1'b0;
        tbl_ok      = 1'b0;
        tbl_we_act  = 1'b0;
        tbl_we_goto = 1'b0;
        tbl_wact    = '0;
        tbl_wgoto   = '0;
        rule_we     = 1'b0;
        rule_waddr  = item_reg.rule_number[RULE_AW-1:0];
        rule_wdata  = '{left: item_reg.rule_left, len: rl_len,
                        first: item_reg.rule_first_right};
        rule_re     = 1'b0;
        rule_raddr  = act_ent.target[RULE_AW-1:0];
        stk_we      = 1'b0;
        stk_waddr   = sp_reg[SA_W-1:0];
        stk_wdata   = '0;
        stk_re      = 1'b0;
        stk_raddr   = sp_pop_m1[SA_W-1:0];
        emit        = 1'b0;
        rec         = '0;
        rec.last    = 1'b1;
        rec.ev      = EV_DONE;

        case (state_reg)
            ST_CLEAR: begin
                tbl_we_act  = 1'b1;
                tbl_we_goto = 1'b1;
                clr_next    = clr_reg + TBL_AW'(1);
                if (clr_reg == TBL_AW'(TBL_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    item_next = s_item;
                    op_next   = lrp_op_t'(s_tuser);
                    if (s_tuser == OP_TOKEN && !done_reg) begin
                        tbl_row    = top_reg;
                        tbl_col    = s_item.table_symbol;
                        tbl_re     = 1'b1;
                        tbl_ok     = in_tbl(top_reg, s_item.table_symbol);
                        n_next     = '0;
                        state_next = ST_ACT;
                    end else begin
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_EXEC: begin
                tbl_row       = item_reg.table_state;
                tbl_col       = item_reg.table_symbol;
                tbl_wact      = '{kind: lrp_kind_t'(item_reg.action_kind),
                                  target: item_reg.entry_target};
                tbl_wgoto     = '{valid: item_reg.goto_valid, target: item_reg.entry_target};
                rec.new_state = top_reg;
                if (out_free) begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                    case (op_reg)
                        OP_LOAD_ACTION: begin
                            tbl_we_act = in_tbl(item_reg.table_state, item_reg.table_symbol);
                        end
                        OP_LOAD_GOTO: begin
                            tbl_we_goto = in_tbl(item_reg.table_state, item_reg.table_symbol);
                        end
                        OP_LOAD_RULE: begin
                            rule_we = (int'(item_reg.rule_number) < RULE_COUNT);
                        end
                        OP_START: begin
                            stk_we        = 1'b1;
                            stk_waddr     = '0;
                            stk_wdata     = '0;
                            sp_next       = SP_W'(1);
                            top_next      = '0;
                            done_next     = 1'b0;
                            rec.new_state = '0;
                        end
                        default: begin
                            rec.ev = EV_IGNORED;
                        end
                    endcase
                end
            end
            ST_ACT: begin
                rec.new_state    = top_reg;
                rec.error_state  = top_reg;
                rec.error_symbol = item_reg.table_symbol;
                if (out_free) begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                    if (sp_reg == '0) begin
                        rec.ev        = EV_STACKERR;
                        rec.new_state = '0;
                    end else if (act_ent.kind == ACT_REJECT ||
                                 (act_ent.kind == ACT_REDUCE &&
                                  int'(act_ent.target) >= RULE_COUNT)) begin
                        rec.ev = EV_ACTERR;
                    end else if (act_ent.kind == ACT_SHIFT) begin
                        if (int'(sp_reg) >= STACK_DEPTH) begin
                            rec.ev = EV_STACKERR;
                        end else begin
                            stk_we           = 1'b1;
                            stk_wdata        = act_ent.target;
                            sp_next          = sp_reg + SP_W'(1);
                            top_next         = act_ent.target;
                            done_next        = 1'b0;
                            rec.ev           = EV_SHIFT;
                            rec.new_state    = act_ent.target;
                            rec.error_state  = '0;
                            rec.error_symbol = '0;
                        end
                    end else if (act_ent.kind == ACT_ACCEPT) begin
                        rec.ev           = EV_ACCEPT;
                        rec.reduced_rule = act_ent.target[RULE_W-1:0];
                        rec.error_state  = '0;
                        rec.error_symbol = '0;
                    end else if (n_reg == N_W'(RESULT_LIMIT - 1)) begin
                        rec.ev = EV_STACKERR;
                    end else begin
                        emit       = 1'b0;
                        done_next  = 1'b0;
                        rule_re    = 1'b1;
                        rnum_next  = act_ent.target[RULE_W-1:0];
                        state_next = ST_RULE;
                    end
                end
            end
            ST_RULE: begin
                rec.ev           = EV_STACKERR;
                rec.new_state    = top_reg;
                rec.error_state  = top_reg;
                rec.error_symbol = rule_rd_reg.left;
                if (int'(eff_len) >= int'(sp_reg)) begin
                    if (out_free) begin
                        emit       = 1'b1;
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end else begin
                    left_next  = rule_rd_reg.left;
                    len_next   = eff_len;
                    sp_next    = sp_pop;
                    stk_re     = 1'b1;
                    state_next = ST_POP;
                end
            end
            ST_POP: begin
                top_next   = gs;
                tbl_row    = gs;
                tbl_col    = left_reg;
                tbl_re     = 1'b1;
                tbl_ok     = in_tbl(gs, left_reg);
                state_next = ST_GOTO;
            end
            ST_GOTO: begin
                rec.new_state    = top_reg;
                rec.error_state  = top_reg;
                rec.error_symbol = left_reg;
                tbl_row          = goto_ent.target;
                tbl_col          = item_reg.table_symbol;
                if (out_free) begin
                    emit = 1'b1;
                    if (!goto_ent.valid) begin
                        rec.ev     = EV_GOTOERR;
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end else if (int'(sp_reg) >= STACK_DEPTH) begin
                        rec.ev     = EV_STACKERR;
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        stk_we           = 1'b1;
                        stk_wdata        = goto_ent.target;
                        sp_next          = sp_reg + SP_W'(1);
                        top_next         = goto_ent.target;
                        n_next           = n_reg + N_W'(1);
                        rec.ev           = EV_REDUCE;
                        rec.last         = 1'b0;
                        rec.new_state    = goto_ent.target;
                        rec.reduced_rule = rnum_reg;
                        rec.error_state  = '0;
                        rec.error_symbol = '0;
                        tbl_re           = 1'b1;
                        tbl_ok           = in_tbl(goto_ent.target, item_reg.table_symbol);
                        state_next       = ST_ACT;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `LRP_ASSERT_IMPL(a_sp_bound, aclk, aresetn, 1'b1, int'(sp_reg) <= STACK_DEPTH)
    `LRP_ASSERT_IMPL(a_parse_has_state, aclk, aresetn, !done_reg, sp_reg != '0)
    `LRP_ASSERT_IMPL(a_clear_quiet, aclk, aresetn, state_reg == ST_CLEAR, !m_tvalid && !s_tready)
    `LRP_ASSERT_NEXT(a_end_sets_done, aclk, aresetn, parse_end, done_reg)

endmodule

/* bench/lr_parse_monitor.sv */
`timescale 1ns / 1ps
// Scoreboard for the LR table parse engine: follows the config, item and record
// channels, predicts every record with its own parser model and compares in order.
// Depends on lrp_pkg.
module lr_parse_monitor (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [lrp_pkg::SYM_W-1:0]       cfg_data,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [lrp_pkg::IN_DATA_W-1:0]   s_tdata,
    input  logic [lrp_pkg::OP_W-1:0]        s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [lrp_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  logic [lrp_pkg::EV_W-1:0]        m_tuser,
    input  logic                            m_tlast,
    output int                              mismatch_count,
    output int                              records_pending
);
    import lrp_pkg::*;

    localparam int TBL_SIZE = 1 << (STATE_W + SYM_W);
    localparam int DEPTH    = STACK_DEPTH_DEF;

    typedef struct packed {
        lrp_ev_t            ev;
        logic [STATE_W-1:0] new_state;
        logic [RULE_W-1:0]  rule;
        logic [STATE_W-1:0] err_state;
        logic [SYM_W-1:0]   err_sym;
        logic               last;
    } parse_rec_t;

    lrp_kind_t          act_kind   [TBL_SIZE];
    logic [TGT_W-1:0]   act_tgt    [TBL_SIZE];
    logic               goto_ok    [TBL_SIZE];
    logic [TGT_W-1:0]   goto_tgt   [TBL_SIZE];
    logic [SYM_W-1:0]   rule_lhs   [RULE_COUNT_DEF];
    logic [LEN_W-1:0]   rule_len   [RULE_COUNT_DEF];
    logic [SYM_W-1:0]   rule_first [RULE_COUNT_DEF];
    logic [STATE_W-1:0] stack_mem  [DEPTH];
    int                 depth;
    bit                 parse_idle;
    logic [SYM_W-1:0]   epsilon;
    parse_rec_t         records_due[$];

    function automatic logic [STATE_W-1:0] stack_top();
        return (depth == 0) ? 8'd0 : stack_mem[depth-1];
    endfunction

    function automatic void queue_record(lrp_ev_t ev, logic [STATE_W-1:0] ns,
                                         logic [RULE_W-1:0] rr, logic [STATE_W-1:0] es,
                                         logic [SYM_W-1:0] esym, logic lst);
        parse_rec_t r;
        r.ev        = ev;
        r.new_state = ns;
        r.rule      = rr;
        r.err_state = es;
        r.err_sym   = esym;
        r.last      = lst;
        records_due.insert(records_due.size(), r);
    endfunction

    function automatic void reset_model();
        for (int i = 0; i < TBL_SIZE; i++) begin
            act_kind[i] = ACT_REJECT;
            act_tgt[i]  = 8'd0;
            goto_ok[i]  = 1'b0;
            goto_tgt[i] = 8'd0;
        end
        for (int i = 0; i < RULE_COUNT_DEF; i++) begin
            rule_lhs[i]   = 6'd0;
            rule_len[i]   = 4'd0;
            rule_first[i] = 6'd0;
        end
        for (int i = 0; i < DEPTH; i++) stack_mem[i] = 8'd0;
        depth          = 0;
        parse_idle     = 1'b1;
        epsilon        = 6'd0;
        mismatch_count = 0;
        records_due.delete();
    endfunction

    // shift/reduce chain for one token; reduce records never end the item
    function automatic void run_token(logic [SYM_W-1:0] sym);
        logic [STATE_W-1:0] top;
        logic [STATE_W-1:0] gs;
        logic [TGT_W-1:0]   tgt;
        lrp_kind_t          kind;
        logic [RULE_W-1:0]  rn;
        logic [SYM_W-1:0]   lhs;
        int                 len;
        int                 n;
        bit                 ended;
        bit                 shifted;
        n       = 0;
        ended   = 1'b0;
        shifted = 1'b0;
        while (!ended) begin
            top   = stack_top();
            kind  = act_kind[{top, sym}];
            tgt   = act_tgt[{top, sym}];
            ended = 1'b1;
            if (depth == 0) begin
                queue_record(EV_STACKERR, 8'd0, 7'd0, top, sym, 1'b1);
            end else if (kind == ACT_REJECT ||
                         (kind == ACT_REDUCE && int'(tgt) >= RULE_COUNT_DEF)) begin
                queue_record(EV_ACTERR, top, 7'd0, top, sym, 1'b1);
            end else if (kind == ACT_SHIFT) begin
                if (depth >= DEPTH) begin
                    queue_record(EV_STACKERR, top, 7'd0, top, sym, 1'b1);
                end else begin
                    stack_mem[depth] = tgt;
                    depth++;
                    shifted = 1'b1;
                    queue_record(EV_SHIFT, tgt, 7'd0, 8'd0, 6'd0, 1'b1);
                end
            end else if (kind == ACT_ACCEPT) begin
                queue_record(EV_ACCEPT, top, tgt[RULE_W-1:0], 8'd0, 6'd0, 1'b1);
            end else if (n >= RESULT_LIMIT - 1) begin
                queue_record(EV_STACKERR, top, 7'd0, top, sym, 1'b1);
            end else begin
                rn  = tgt[RULE_W-1:0];
                lhs = rule_lhs[rn];
                len = int'(rule_len[rn]);
                if (len == 1 && rule_first[rn] == epsilon) len = 0;
                if (len >= depth) begin
                    queue_record(EV_STACKERR, top, 7'd0, top, lhs, 1'b1);
                end else begin
                    depth -= len;
                    gs = stack_top();
                    if (!goto_ok[{gs, lhs}]) begin
                        queue_record(EV_GOTOERR, gs, 7'd0, gs, lhs, 1'b1);
                    end else if (depth >= DEPTH) begin
                        queue_record(EV_STACKERR, gs, 7'd0, gs, lhs, 1'b1);
                    end else begin
                        stack_mem[depth] = goto_tgt[{gs, lhs}];
                        depth++;
                        queue_record(EV_REDUCE, goto_tgt[{gs, lhs}], rn, 8'd0, 6'd0, 1'b0);
                        ended = 1'b0;
                    end
                end
            end
            n++;
        end
        if (!shifted) parse_idle = 1'b1;
    endfunction

    function automatic void parse_step(logic [OP_W-1:0] op, lrp_item_t it);
        case (op)
            OP_LOAD_ACTION: begin
                act_kind[{it.table_state, it.table_symbol}] = lrp_kind_t'(it.action_kind);
                act_tgt[{it.table_state, it.table_symbol}]  = it.entry_target;
                queue_record(EV_DONE, stack_top(), 7'd0, 8'd0, 6'd0, 1'b1);
            end
            OP_LOAD_GOTO: begin
                goto_ok[{it.table_state, it.table_symbol}]  = it.goto_valid;
                goto_tgt[{it.table_state, it.table_symbol}] = it.entry_target;
                queue_record(EV_DONE, stack_top(), 7'd0, 8'd0, 6'd0, 1'b1);
            end
            OP_LOAD_RULE: begin
                rule_lhs[it.rule_number]   = it.rule_left;
                rule_len[it.rule_number]   = it.rule_length;
                rule_first[it.rule_number] = it.rule_first_right;
                queue_record(EV_DONE, stack_top(), 7'd0, 8'd0, 6'd0, 1'b1);
            end
            OP_TOKEN: begin
                if (parse_idle)
                    queue_record(EV_IGNORED, stack_top(), 7'd0, 8'd0, 6'd0, 1'b1);
                else
                    run_token(it.table_symbol);
            end
            OP_START: begin
                stack_mem[0] = 8'd0;
                depth        = 1;
                parse_idle   = 1'b0;
                queue_record(EV_DONE, 8'd0, 7'd0, 8'd0, 6'd0, 1'b1);
            end
            default: queue_record(EV_IGNORED, stack_top(), 7'd0, 8'd0, 6'd0, 1'b1);
        endcase
    endfunction

    function automatic void check_record();
        parse_rec_t got;
        parse_rec_t want;
        got.ev        = lrp_ev_t'(m_tuser);
        got.new_state = m_tdata[7:0];
        got.rule      = m_tdata[14:8];
        got.err_state = m_tdata[22:15];
        got.err_sym   = m_tdata[28:23];
        got.last      = m_tlast;
        if (records_due.size() == 0) begin
            mismatch_count++;
            $display({"%0t: record mismatch: expected none, actual ev=%0d ns=%0d ",
                      "rule=%0d es=%0d esym=%0d last=%0d"},
                     $time, got.ev, got.new_state, got.rule, got.err_state, got.err_sym,
                     got.last);
        end else begin
            want = records_due.pop_front();
            if (got !== want) begin
                mismatch_count++;
                $display({"%0t: record mismatch: expected ev=%0d ns=%0d rule=%0d es=%0d ",
                          "esym=%0d last=%0d, actual ev=%0d ns=%0d rule=%0d es=%0d ",
                          "esym=%0d last=%0d"},
                         $time, want.ev, want.new_state, want.rule, want.err_state,
                         want.err_sym, want.last, got.ev, got.new_state, got.rule,
                         got.err_state, got.err_sym, got.last);
            end
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            reset_model();
        end else begin
            if (m_tvalid && m_tready) check_record();
            if (cfg_valid && cfg_ready) epsilon = cfg_data;
            if (s_tvalid && s_tready) parse_step(s_tuser, lrp_item_t'(s_tdata));
        end
        records_pending = records_due.size();
    end

endmodule

/* bench/lr_table_parse_engine_test.sv */
`timescale 1ns / 1ps
// Top of the LR table parse engine bench: clock, reset, item and config stimulus,
// random back-pressure, verdict. Depends on lrp_pkg, the engine and lr_parse_monitor.
module lr_table_parse_engine_test;
    import lrp_pkg::*;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [SYM_W-1:0]      cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic [OP_W-1:0]       s_tuser   = '0;
    logic                  m_tready  = 1'b0;
    logic                  cfg_ready;
    logic                  s_tready;
    logic                  m_tvalid;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [EV_W-1:0]       m_tuser;
    logic                  m_tlast;
    int                    error_count;
    int                    records_pending;
    bit                    no_gaps     = 1'b0;
    bit                    hold_off    = 1'b0;
    bit                    squeeze_req = 1'b0;

    always #5 aclk = ~aclk;

    lr_table_parse_engine dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    lr_parse_monitor monitor (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .mismatch_count  (error_count),
        .records_pending (records_pending)
    );

    always @(negedge aclk) begin
        m_tready <= !hold_off && (no_gaps || $urandom_range(99) >= 30);
    end

    // long receiver stall so the engine backs up into its input
    initial begin
        wait (squeeze_req);
        @(negedge aclk);
        hold_off <= 1'b1;
        repeat (400) @(negedge aclk);
        hold_off <= 1'b0;
    end

    initial begin
        #(10_000_000);
        $display("DONE: errors detected");
        $finish;
    end

    function automatic lrp_item_t scrambled();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[IN_DATA_W-1:0];
    endfunction

    task automatic push_item(logic [OP_W-1:0] op, lrp_item_t it);
        while (!no_gaps && $urandom_range(99) < 30) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= it;
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic load_action(logic [STATE_W-1:0] st, logic [SYM_W-1:0] sym,
                               lrp_kind_t kind, logic [TGT_W-1:0] tgt);
        lrp_item_t it = scrambled();
        it.table_state  = st;
        it.table_symbol = sym;
        it.action_kind  = kind;
        it.entry_target = tgt;
        push_item(OP_LOAD_ACTION, it);
    endtask

    task automatic load_goto(logic [STATE_W-1:0] st, logic [SYM_W-1:0] sym, logic ok,
                             logic [TGT_W-1:0] tgt);
        lrp_item_t it = scrambled();
        it.table_state  = st;
        it.table_symbol = sym;
        it.goto_valid   = ok;
        it.entry_target = tgt;
        push_item(OP_LOAD_GOTO, it);
    endtask

    task automatic load_rule(logic [RULE_W-1:0] rn, logic [SYM_W-1:0] lhs,
                             logic [LEN_W-1:0] len, logic [SYM_W-1:0] first);
        lrp_item_t it = scrambled();
        it.rule_number      = rn;
        it.rule_left        = lhs;
        it.rule_length      = len;
        it.rule_first_right = first;
        push_item(OP_LOAD_RULE, it);
    endtask

    task automatic token(logic [SYM_W-1:0] sym);
        lrp_item_t it = scrambled();
        it.table_symbol = sym;
        push_item(OP_TOKEN, it);
    endtask

    task automatic start_parse();
        push_item(OP_START, scrambled());
    endtask

    task automatic odd_op();
        push_item(3'(5 + $urandom_range(2)), scrambled());
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (records_pending != 0) @(negedge aclk);
    endtask

    task automatic write_epsilon(logic [SYM_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // small random grammar over a handful of states and symbols, then parses
    task automatic random_phase(logic [SYM_W-1:0] eps, int parses);
        logic [STATE_W-1:0] states[6];
        logic [SYM_W-1:0]   terms[4];
        logic [SYM_W-1:0]   nts[2];
        logic [RULE_W-1:0]  rules[4];
        lrp_kind_t          kind;
        logic [TGT_W-1:0]   tgt;
        int                 pick;
        int                 ntok;
        states[0] = 8'd0;
        for (int i = 1; i < 6; i++) states[i] = 8'($urandom_range(255));
        for (int i = 0; i < 4; i++) terms[i] = 6'($urandom_range(63));
        for (int i = 0; i < 2; i++) nts[i] = 6'($urandom_range(63));
        for (int r = 0; r < 4; r++) begin
            rules[r] = 7'($urandom_range(127));
            pick = $urandom_range(99);
            if (pick < 60)
                load_rule(rules[r], nts[$urandom_range(1)], 4'($urandom_range(2)),
                          6'($urandom_range(63)));
            else if (pick < 80)
                load_rule(rules[r], nts[$urandom_range(1)], 4'd1, eps);
            else
                load_rule(rules[r], nts[$urandom_range(1)], 4'($urandom_range(15)),
                          6'($urandom_range(63)));
        end
        for (int s = 0; s < 6; s++) begin
            for (int t = 0; t < 4; t++) begin
                pick = $urandom_range(99);
                if (pick < 35) begin
                    kind = ACT_SHIFT;
                    tgt  = states[$urandom_range(5)];
                end else if (pick < 70) begin
                    kind = ACT_REDUCE;
                    tgt  = (pick < 66) ? {1'b0, rules[$urandom_range(3)]}
                                       : 8'(128 + $urandom_range(127));
                end else if (pick < 80) begin
                    kind = ACT_ACCEPT;
                    tgt  = 8'($urandom_range(255));
                end else begin
                    kind = ACT_REJECT;
                    tgt  = 8'($urandom_range(255));
                end
                load_action(states[s], terms[t], kind, tgt);
            end
        end
        for (int s = 0; s < 6; s++)
            for (int n = 0; n < 2; n++)
                load_goto(states[s], nts[n], $urandom_range(99) < 85,
                          states[$urandom_range(5)]);
        for (int p = 0; p < parses; p++) begin
            start_parse();
            ntok = $urandom_range(12, 3);
            for (int k = 0; k < ntok; k++) begin
                pick = $urandom_range(99);
                if (pick < 8)
                    odd_op();
                else if (pick < 18)
                    token(6'($urandom_range(63)));
                else
                    token(terms[$urandom_range(3)]);
            end
        end
    endtask

    initial begin
        logic [SYM_W-1:0]   eps;
        logic [STATE_W-1:0] loop_st;
        logic [SYM_W-1:0]   sym_b;
        logic [SYM_W-1:0]   sym_c;
        logic [SYM_W-1:0]   nt;
        logic [RULE_W-1:0]  eps_rule;

        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        write_epsilon(6'd0);

        // directed: idle token, unknown op, a short accepted parse, each error kind
        token(6'd9);
        odd_op();
        load_rule(7'd0, 6'd1, 4'd2, 6'd17);
        load_rule(7'd1, 6'd2, 4'd1, 6'd0);
        load_rule(7'd127, 6'd63, 4'd15, 6'd63);
        load_action(8'd0, 6'd5, ACT_SHIFT, 8'd255);
        load_action(8'd255, 6'd63, ACT_REDUCE, 8'd1);
        load_action(8'd3, 6'd63, ACT_REDUCE, 8'd0);
        load_action(8'd200, 6'd63, ACT_ACCEPT, 8'd255);
        load_action(8'd0, 6'd1, ACT_REDUCE, 8'd128);
        load_action(8'd0, 6'd2, ACT_REDUCE, 8'd1);
        load_action(8'd0, 6'd3, ACT_REDUCE, 8'd127);
        load_goto(8'd0, 6'd1, 1'b1, 8'd200);
        load_goto(8'd255, 6'd2, 1'b1, 8'd3);
        start_parse();
        token(6'd5);
        token(6'd63);
        token(6'd63);
        start_parse();
        token(6'd0);
        start_parse();
        token(6'd1);
        start_parse();
        token(6'd2);
        start_parse();
        token(6'd3);

        // stack stress: epsilon self-loop hits the chain limit and reduce overflow,
        // a shift self-loop fills the stack
        settle();
        write_epsilon(6'd63);
        loop_st  = 8'(1 + $urandom_range(254));
        sym_b    = 6'($urandom_range(63));
        sym_c    = sym_b ^ 6'(1 + $urandom_range(62));
        nt       = 6'($urandom_range(63));
        eps_rule = 7'($urandom_range(127));
        load_rule(eps_rule, nt, 4'd1, 6'd63);
        load_action(8'd0, sym_b, ACT_SHIFT, loop_st);
        load_action(loop_st, sym_b, ACT_SHIFT, loop_st);
        load_action(8'd0, sym_c, ACT_REDUCE, {1'b0, eps_rule});
        load_action(loop_st, sym_c, ACT_REDUCE, {1'b0, eps_rule});
        load_goto(8'd0, nt, 1'b1, loop_st);
        load_goto(loop_st, nt, 1'b1, loop_st);
        start_parse();
        token(sym_c);
        start_parse();
        token(sym_b);
        token(sym_c);
        start_parse();
        repeat (64) token(sym_b);
        token(sym_c);

        settle();
        eps = 6'($urandom_range(63));
        write_epsilon(eps);
        squeeze_req <= 1'b1;
        random_phase(eps, 5);

        settle();
        eps = 6'($urandom_range(63));
        write_epsilon(eps);
        no_gaps <= 1'b1;
        random_phase(eps, 5);

        settle();
        no_gaps <= 1'b0;
        eps = 6'($urandom_range(63));
        write_epsilon(eps);
        random_phase(eps, 5);

        settle();
        repeat (400) @(negedge aclk);
        if (error_count == 0 && records_pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/lrp_pkg.sv
rtl/lr_table_parse_engine.sv
bench/lr_parse_monitor.sv
bench/lr_table_parse_engine_test.sv
